>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication with reset disable.
`define ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication with reset disable.
`define ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/trcd_pkg.sv
// Package for the result cache directory: widths, op and register codes.
// Used by the front, queue, back and top modules; depends on nothing.
package trcd_pkg;

  localparam int unsigned EntriesDef = 32;
  localparam int unsigned LenLimit   = 16 * 1024;
  localparam logic [7:0]  TtlReset   = 8'd5;
  localparam logic [14:0] MaxLenReset = 15'd16384;

  localparam logic [1:0] OP_LOOKUP     = 2'd0;
  localparam logic [1:0] OP_STORE      = 2'd1;
  localparam logic [1:0] OP_INVALIDATE = 2'd2;

  localparam logic REG_TTL    = 1'b0;
  localparam logic REG_MAXLEN = 1'b1;

  localparam int unsigned InW  = 152;
  localparam int unsigned OutW = 21;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now;
    logic [63:0] city;
    logic [31:0] user_id;
    logic        is_operator;
    logic        is_archived;
    logic [19:0] payload_len;
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } exec_state_e;

endpackage

>>> rtl/trcd_front.sv
// Front part: accepts request words, decodes fields, applies the length check.
// Depends on trcd_pkg; feeds the request queue.
module trcd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [159:0]        in_data_i,
  input  logic [14:0]         max_len_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output trcd_pkg::req_t      q_req_o
);

  trcd_pkg::req_t req_d, req_q;
  logic           vld_q;
  logic           len_ok;

  always_comb begin
    req_d.op          = in_data_i[1:0];
    req_d.now         = in_data_i[33:2];
    req_d.city        = in_data_i[97:34];
    req_d.user_id     = in_data_i[129:98];
    req_d.is_operator = in_data_i[130];
    req_d.is_archived = in_data_i[131];
    req_d.payload_len = in_data_i[151:132];
    len_ok = (req_d.payload_len < {5'd0, max_len_i}) &&
             (req_d.payload_len < 20'(trcd_pkg::LenLimit));
    // A rejected store becomes an unused code so the back part writes nothing.
    if (req_d.op == trcd_pkg::OP_STORE && !len_ok) req_d.op = 2'd3;
  end

  assign in_ready_o = !vld_q || q_ready_i;
  assign q_valid_o  = vld_q;
  assign q_req_o    = req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) req_q <= req_d;
  end

endmodule

>>> rtl/trcd_queue.sv
// Two-entry request queue between front and back parts.
// Depends on trcd_pkg for the request type.
module trcd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  trcd_pkg::req_t wr_req_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output trcd_pkg::req_t rd_req_o
);

  trcd_pkg::req_t mem_q [2];
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_req_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_valid_i && wr_ready_o) wp_q <= !wp_q;
      if (rd_valid_o && rd_ready_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(wr_valid_i && wr_ready_o) - 2'(rd_valid_o && rd_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_valid_i && wr_ready_o) mem_q[wp_q] <= wr_req_i;
  end

endmodule

>>> rtl/trcd_back.sv
// Back part: entry store, parallel match, oldest-stamp search, result register.
// Depends on trcd_pkg.
module trcd_back #(
  parameter int unsigned Entries = trcd_pkg::EntriesDef,
  localparam int unsigned IdxW = $clog2(Entries)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  trcd_pkg::req_t q_req_i,
  input  logic [7:0]     ttl_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [20:0]    out_data_o
);

  localparam int unsigned NP = 1 << IdxW;

  trcd_pkg::exec_state_e state_q, state_d;
  trcd_pkg::req_t        req_q;

  logic [Entries-1:0] valid_q;
  logic [63:0] city_q  [Entries];
  logic [31:0] user_q  [Entries];
  logic        oper_q  [Entries];
  logic        arch_q  [Entries];
  logic [31:0] stamp_q [Entries];
  logic [13:0] len_q   [Entries];

  // Per-entry classification, registered in the scan cycle.
  logic [Entries-1:0] exp_d, match_d, city_hit_d, kill_d;
  logic [Entries-1:0] exp_q, match_q, kill_q;

  // Oldest-stamp search as a balanced tree of compare-and-select nodes;
  // the left child covers lower indices and wins ties.
  logic [31:0]     tree_stamp [2*NP];
  logic [IdxW-1:0] tree_idx   [2*NP];
  logic [IdxW-1:0] old_d, old_q, free_d, free_q, hit_idx;
  logic            any_free_d, any_free_q, any_hit;
  logic [Entries-1:0] live_before;

  logic        res_vld_q;
  logic [20:0] res_q;
  logic [20:0] res_d;

  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      exp_d[i] = (req_q.now > stamp_q[i]) &&
                 ((req_q.now - stamp_q[i]) > {24'd0, ttl_i});
      city_hit_d[i] = city_q[i] == req_q.city;
      match_d[i] = city_hit_d[i] && user_q[i] == req_q.user_id &&
                   oper_q[i] == req_q.is_operator && arch_q[i] == req_q.is_archived;
      kill_d[i] = valid_q[i] && city_hit_d[i] && (oper_q[i] || user_q[i] == req_q.user_id);
    end
  end

  always_comb begin
    any_free_d = 1'b0;
    free_d = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        any_free_d = 1'b1;
        free_d = IdxW'(i);
      end
    end
    tree_stamp[0] = '0;
    tree_idx[0]   = '0;
    for (int i = 0; i < NP; i++) begin
      if (i < Entries) tree_stamp[NP+i] = stamp_q[i];
      else             tree_stamp[NP+i] = '1;
      tree_idx[NP+i] = IdxW'(i);
    end
    for (int n = NP - 1; n >= 1; n--) begin
      if (tree_stamp[2*n+1] < tree_stamp[2*n]) begin
        tree_stamp[n] = tree_stamp[2*n+1];
        tree_idx[n]   = tree_idx[2*n+1];
      end else begin
        tree_stamp[n] = tree_stamp[2*n];
        tree_idx[n]   = tree_idx[2*n];
      end
    end
    old_d = tree_idx[1];
  end

  // First live, unexpired match; on a lookup, entries before it (all entries
  // when there is no match) that are live and expired get cleared.
  always_comb begin
    any_hit = 1'b0;
    hit_idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (valid_q[i] && !exp_q[i] && match_q[i]) begin
        any_hit = 1'b1;
        hit_idx = IdxW'(i);
      end
    end
    for (int i = 0; i < Entries; i++) begin
      live_before[i] = !any_hit || (IdxW'(i) < hit_idx);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      trcd_pkg::ST_IDLE:  if (q_valid_i) state_d = trcd_pkg::ST_SCAN;
      trcd_pkg::ST_SCAN:  state_d = trcd_pkg::ST_WRITE;
      trcd_pkg::ST_WRITE: state_d = trcd_pkg::ST_DONE;
      trcd_pkg::ST_DONE:  if (!res_vld_q || out_ready_i) state_d = trcd_pkg::ST_IDLE;
      default:            state_d = trcd_pkg::ST_IDLE;
    endcase
  end

  assign q_ready_o = state_q == trcd_pkg::ST_IDLE;

  logic [IdxW-1:0] pick;
  always_comb begin
    pick = any_free_q ? free_q : old_q;
    res_d = '0;
    if (req_q.op == trcd_pkg::OP_LOOKUP && any_hit) begin
      res_d[0]    = 1'b1;
      res_d[5:1]  = 5'(hit_idx);
      res_d[19:6] = len_q[hit_idx];
    end else if (req_q.op == trcd_pkg::OP_STORE) begin
      res_d[5:1] = 5'(pick);
      res_d[20]  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= trcd_pkg::ST_IDLE;
      valid_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == trcd_pkg::ST_WRITE) begin
        unique case (req_q.op)
          trcd_pkg::OP_LOOKUP:     valid_q <= valid_q & ~(exp_q & live_before);
          trcd_pkg::OP_STORE:      valid_q[pick] <= 1'b1;
          trcd_pkg::OP_INVALIDATE: valid_q <= valid_q & ~kill_q;
          default:                 valid_q <= valid_q;
        endcase
      end
      if (state_q == trcd_pkg::ST_DONE && (!res_vld_q || out_ready_i)) begin
        res_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o) req_q <= q_req_i;
    if (state_q == trcd_pkg::ST_SCAN) begin
      exp_q <= exp_d;
      match_q <= match_d;
      kill_q <= kill_d;
      old_q <= old_d;
      free_q <= free_d;
      any_free_q <= any_free_d;
    end
    if (state_q == trcd_pkg::ST_WRITE) begin
      if (req_q.op == trcd_pkg::OP_STORE) begin
        city_q[pick]  <= req_q.city;
        user_q[pick]  <= req_q.user_id;
        oper_q[pick]  <= req_q.is_operator;
        arch_q[pick]  <= req_q.is_archived;
        stamp_q[pick] <= req_q.now;
        len_q[pick]   <= req_q.payload_len[13:0];
      end
    end
    // The result register is loaded only once the previous word has left.
    if (state_q == trcd_pkg::ST_DONE && (!res_vld_q || out_ready_i)) res_q <= res_d;
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

endmodule

>>> rtl/ttl_result_cache_directory.sv
// Result cache directory: a fully associative store of keyed entries with
// lazy age expiry, oldest-stamp eviction and city invalidation. Each request
// word passes through the back part's states (issue, parallel compare and
// oldest/free search, state update, result) one at a time, through its single
// compare array; the front part and a two-word queue accept words meanwhile.
// A result waits in its output register until taken.
module ttl_result_cache_directory #(
  parameter int unsigned Entries = trcd_pkg::EntriesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op, now, city, user_id, is_operator, is_archived, payload_len, zero fill
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit, slot, entry_len, stored, zero fill
  output logic [23:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [14:0]  cfg_data_i
);

  logic [7:0]  ttl_q;
  logic [14:0] maxlen_q;
  logic        fq_valid, fq_ready, qb_valid, qb_ready;
  trcd_pkg::req_t fq_req, qb_req;
  logic [20:0] res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q    <= trcd_pkg::TtlReset;
      maxlen_q <= trcd_pkg::MaxLenReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        trcd_pkg::REG_TTL:    ttl_q <= cfg_data_i[7:0];
        trcd_pkg::REG_MAXLEN: maxlen_q <= cfg_data_i;
        default:              ttl_q <= ttl_q;
      endcase
    end
  end

  trcd_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_data_i(s_axis_tdata),
    .max_len_i(maxlen_q),
    .q_valid_o(fq_valid), .q_ready_i(fq_ready), .q_req_o(fq_req)
  );

  trcd_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fq_valid), .wr_ready_o(fq_ready), .wr_req_i(fq_req),
    .rd_valid_o(qb_valid), .rd_ready_i(qb_ready), .rd_req_o(qb_req)
  );

  trcd_back #(.Entries(Entries)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(qb_valid), .q_ready_o(qb_ready), .q_req_i(qb_req),
    .ttl_i(ttl_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(res)
  );

  assign m_axis_tdata = {3'd0, res};

endmodule

>>> rtl/trcd_checker.sv
// Port-level checker for the result cache directory, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module trcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "word dropped")
  `ASSERT_IMP(a_hit_store, clk_i, rst_ni, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[20]), "hit and stored")
  `ASSERT_IMP(a_miss_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[19:6] == 14'd0, "length on miss")
  `ASSERT_IMP(a_pad, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[23:21] == 3'd0, "fill bits set")

endmodule

bind ttl_result_cache_directory trcd_checker u_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
